### rtl/reciprocal_frequency_meter_unit_macros.svh
// assertion macros for the reciprocal frequency meter
// used by reciprocal_frequency_meter_unit.sv, no other dependencies
`ifndef RECIPROCAL_FREQUENCY_METER_UNIT_MACROS_SVH
`define RECIPROCAL_FREQUENCY_METER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RFM_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("rfm assertion failed");

// next-cycle implication, disabled during reset
`define RFM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("rfm assertion failed");

`endif

### rtl/rfm_pkg.sv
// shared constants and types for the reciprocal frequency meter
// no dependencies
package rfm_pkg;

   // timer and register widths
   localparam int TIMER_WIDTH  = 16;
   localparam int CLOCK_WIDTH  = 30;
   localparam logic [CLOCK_WIDTH-1:0] CLOCK_RESET = 30'd15100000;

   // decimal digit output
   localparam int DIGITS       = 8;
   localparam int DIGIT_FIELDS = 8;
   localparam int DIGIT_WIDTH  = 6;
   localparam int BCD_WIDTH    = DIGITS * 4;
   localparam logic [DIGIT_WIDTH-1:0] ASCII_ZERO = 6'd48;

   // stream widths, padded to whole bytes
   localparam int REQ_TDATA_WIDTH = ((TIMER_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH = ((CLOCK_WIDTH + DIGIT_FIELDS * DIGIT_WIDTH + 7) / 8) * 8;

   // divider step counter
   localparam int CNT_WIDTH = $clog2(CLOCK_WIDTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

### rtl/reciprocal_frequency_meter_unit.sv
// reciprocal frequency meter top level: capture pairing, divider, digit conversion
// depends on rfm_pkg and reciprocal_frequency_meter_unit_macros.svh
//
// Captures arrive in pairs. The first capture of a pair is stored and gives no
// result. The second capture starts a restoring divide of clock_hz by the
// wrapped period, one quotient bit per cycle; each quotient bit is shifted into
// a BCD register at the same time (shift-add-3), so the decimal digits are ready
// with the quotient. A nonzero period goes from accept through the divide steps
// and a load into the result register; a zero period skips the divide. The
// input is not ready while the divider runs or while a finished result waits
// for a full output register. clock_hz may be written only while no pair
// result is outstanding.
`include "reciprocal_frequency_meter_unit_macros.svh"

module reciprocal_frequency_meter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // capture items: [15:0] capture_time
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rfm_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   // result items: [29:0] frequency, [35:30] digit_7, [41:36] digit_6,
   // [47:42] digit_5, [53:48] digit_4, [59:54] digit_3, [65:60] digit_2,
   // [71:66] digit_1, [77:72] digit_0, [79:78] zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rfm_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   // result flags: [0] zero_period
   output logic                                 rsp_tuser,
   // clock_hz register write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rfm_pkg::CLOCK_WIDTH-1:0]      csr_data
);

   localparam int TW = rfm_pkg::TIMER_WIDTH;
   localparam int CW = rfm_pkg::CLOCK_WIDTH;
   localparam int DW = rfm_pkg::DIGIT_WIDTH;
   localparam int BW = rfm_pkg::BCD_WIDTH;

   rfm_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                     clock_hz_ff, clock_hz_in;
   logic [TW-1:0]                     first_ff, first_in;
   logic                              have_first_ff, have_first_in;
   logic [TW-1:0]                     divisor_ff, divisor_in;
   logic [CW-1:0]                     dividend_ff, dividend_in;
   logic [TW-1:0]                     rem_ff, rem_in;
   logic [CW-1:0]                     quot_ff, quot_in;
   logic [BW-1:0]                     bcd_ff, bcd_in;
   logic                              zero_ff, zero_in;
   logic [rfm_pkg::CNT_WIDTH-1:0]     count_ff, count_in;
   logic                              rsp_tvalid_ff, rsp_tvalid_in;
   logic [rfm_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                              rsp_tuser_ff, rsp_tuser_in;

   logic [TW-1:0]                     stamp;
   logic [TW-1:0]                     period;
   logic [TW:0]                       trial;
   logic [TW:0]                       diff;
   logic                              qbit;
   logic [BW-1:0]                     bcd_adj;
   logic [DW-1:0]                     digit_chr [rfm_pkg::DIGIT_FIELDS];
   logic [rfm_pkg::RSP_TDATA_WIDTH-1:0] packed_result;
   logic                              out_free;
   logic                              req_fire;

   assign stamp      = req_tdata[TW-1:0];
   assign period     = stamp - first_ff;
   assign req_tready = (state_ff == rfm_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // divide step: shift in next dividend bit, compare and subtract
   assign trial = {rem_ff, dividend_ff[CW-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign qbit  = (trial >= {1'b0, divisor_ff});

   // bcd digit adjust ahead of the shift
   always_comb begin
      for (int i = 0; i < rfm_pkg::DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // ascii digits, positions past the converted ones read as zero
   for (genvar p = 0; p < rfm_pkg::DIGIT_FIELDS; p++) begin : g_digit
      if (p < rfm_pkg::DIGITS) begin : g_conv
         assign digit_chr[p] = {{(DW-4){1'b0}}, bcd_ff[p*4 +: 4]} + rfm_pkg::ASCII_ZERO;
      end else begin : g_pad
         assign digit_chr[p] = rfm_pkg::ASCII_ZERO;
      end
   end

   // result packing, most significant digit first above the frequency
   always_comb begin
      packed_result = '0;
      packed_result[CW-1:0] = quot_ff;
      for (int k = 0; k < rfm_pkg::DIGIT_FIELDS; k++) begin
         packed_result[CW + k*DW +: DW] = digit_chr[rfm_pkg::DIGIT_FIELDS-1-k];
      end
   end

   // sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      clock_hz_in   = clock_hz_ff;
      first_in      = first_ff;
      have_first_in = have_first_ff;
      divisor_in    = divisor_ff;
      dividend_in   = dividend_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      bcd_in        = bcd_ff;
      zero_in       = zero_ff;
      count_in      = count_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      if (csr_valid) begin
         clock_hz_in = csr_data;
      end

      unique case (state_ff)
         rfm_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (!have_first_ff) begin
                  first_in      = stamp;
                  have_first_in = 1'b1;
               end else begin
                  have_first_in = 1'b0;
                  divisor_in    = period;
                  dividend_in   = clock_hz_ff;
                  rem_in        = '0;
                  quot_in       = '0;
                  bcd_in        = '0;
                  count_in      = '0;
                  zero_in       = (period == '0);
                  state_in      = (period == '0) ? rfm_pkg::ST_FINISH : rfm_pkg::ST_DIVIDE;
               end
            end
         end
         rfm_pkg::ST_DIVIDE: begin
            dividend_in = {dividend_ff[CW-2:0], 1'b0};
            rem_in      = qbit ? diff[TW-1:0] : trial[TW-1:0];
            quot_in     = {quot_ff[CW-2:0], qbit};
            bcd_in      = {bcd_adj[BW-2:0], qbit};
            count_in    = count_ff + 1'b1;
            if (count_ff == rfm_pkg::CNT_WIDTH'(CW - 1)) begin
               state_in = rfm_pkg::ST_FINISH;
            end
         end
         rfm_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = packed_result;
               rsp_tuser_in  = zero_ff;
               state_in      = rfm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rfm_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff   <= rfm_pkg::CLOCK_RESET;
         first_ff      <= '0;
         have_first_ff <= 1'b0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         clock_hz_ff   <= clock_hz_in;
         first_ff      <= first_in;
         have_first_ff <= have_first_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      divisor_ff   <= divisor_in;
      dividend_ff  <= dividend_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      bcd_ff       <= bcd_in;
      zero_ff      <= zero_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // remainder stays below the divisor throughout the divide
   `RFM_ASSERT_NOW(a_rem_below_divisor, clock, reset, state_ff == rfm_pkg::ST_DIVIDE, rem_ff < divisor_ff)
   // a closing capture with a nonzero period starts the divider
   `RFM_ASSERT_NEXT(a_pair_starts_divide, clock, reset, req_fire && have_first_ff && (period != '0), state_ff == rfm_pkg::ST_DIVIDE)
   // a zero period result carries frequency zero
   `RFM_ASSERT_NOW(a_zero_period_freq, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[CW-1:0] == '0)

endmodule
